// File: rtl/elpr_pkg.sv
// Shared types and constants for the edge list parser with node renumbering.
// Used by every module under rtl/ but elpr_fifo; depends on nothing.
`default_nettype none

package elpr_pkg;

   // Default sizes handed down from the top level
   localparam int MAX_NODES_DEFAULT = 65536;
   localparam int CMD_DEPTH_DEFAULT = 4;
   localparam int RSP_DEPTH_DEFAULT = 4;

   // Field widths
   localparam int BYTE_W  = 8;
   localparam int ACC_W   = 18;
   localparam int RAW_W   = 17;
   localparam int DENSE_W = 16;
   localparam int KIND_W  = 2;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 17;

   // Text constants
   localparam logic [BYTE_W-1:0] CHAR_ZERO = 8'd48;
   localparam logic [BYTE_W-1:0] CHAR_NINE = 8'd57;
   localparam logic [3:0]        RADIX     = 4'd10;
   localparam logic [ACC_W-1:0]  ACC_MAX   = 18'h3FFFF;

   // Result kinds
   localparam logic [KIND_W-1:0] KIND_EDGE  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_ERROR = 2'd1;
   localparam logic [KIND_W-1:0] KIND_DONE  = 2'd2;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_NODE_COUNT = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DIRECTED   = 1'd1;

   localparam logic [CSR_DATA_W-1:0] NODE_COUNT_RESET = 17'd65536;

   // Command from the parser front to the renumbering back
   typedef struct packed {
      logic             pair;
      logic             err;
      logic             done;
      logic [RAW_W-1:0] start_raw;
      logic [RAW_W-1:0] end_raw;
   } elpr_cmd_type;

   // One result item
   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [DENSE_W-1:0] source_node;
      logic [DENSE_W-1:0] target_node;
      logic               final_of_run;
   } elpr_rsp_type;

endpackage

`default_nettype wire

// File: rtl/elpr_fifo.sv
// Small first-in first-out queue of any packed item type.
// Depends on nothing but its parameters.
`default_nettype none

module elpr_fifo #(
   parameter type item_type = logic,
   parameter int  DEPTH     = 4
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_data,
   output logic     full,
   input  logic     pop,
   output item_type pop_data,
   output logic     empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   item_type         mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = mem_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage, no reset
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// File: rtl/elpr_front.sv
// Parser front: turns text bytes into numbers, range checks them and
// pairs them into commands. Depends on elpr_pkg.
`default_nettype none

module elpr_front #(
   parameter int MAX_NODES = elpr_pkg::MAX_NODES_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                accept,
   input  logic [elpr_pkg::BYTE_W-1:0]         text_byte,
   input  logic                                end_of_text,
   input  logic [elpr_pkg::CSR_DATA_W-1:0]     node_count,
   output logic                                cmd_push,
   output elpr_pkg::elpr_cmd_type              cmd_data
);

   localparam int WIDE_W = elpr_pkg::ACC_W + 4;

   logic [elpr_pkg::ACC_W-1:0] acc_ff, acc_in;
   logic                       inside_ff, inside_in;
   logic                       have_start_ff, have_start_in;
   logic [elpr_pkg::RAW_W-1:0] start_raw_ff, start_raw_in;
   logic                       stopped_ff, stopped_in;

   logic                       is_digit;
   logic [3:0]                 digit;
   logic [WIDE_W-1:0]          acc_wide;
   logic [elpr_pkg::ACC_W-1:0] acc_sat;
   logic [elpr_pkg::ACC_W-1:0] value;
   logic                       completed;
   logic                       out_of_range;
   logic                       live;

   // digit accumulate with saturation
   always_comb begin
      is_digit = (text_byte >= elpr_pkg::CHAR_ZERO) && (text_byte <= elpr_pkg::CHAR_NINE);
      digit    = 4'(text_byte - elpr_pkg::CHAR_ZERO);
      acc_wide = WIDE_W'(acc_ff) * WIDE_W'(elpr_pkg::RADIX) + WIDE_W'(digit);
      acc_sat  = (acc_wide > WIDE_W'(elpr_pkg::ACC_MAX)) ? elpr_pkg::ACC_MAX
                                                        : acc_wide[elpr_pkg::ACC_W-1:0];
      value     = is_digit ? acc_sat : acc_ff;
      completed = is_digit ? end_of_text : inside_ff;
      out_of_range = (value >= elpr_pkg::ACC_W'(node_count)) ||
                     (32'(value) >= 32'(MAX_NODES));
      live = accept && !stopped_ff;
   end

   // command out
   always_comb begin
      cmd_data.pair      = completed && !out_of_range && have_start_ff;
      cmd_data.err       = completed && out_of_range;
      cmd_data.done      = end_of_text && !(completed && out_of_range);
      cmd_data.start_raw = start_raw_ff;
      cmd_data.end_raw   = value[elpr_pkg::RAW_W-1:0];
      cmd_push = live && (cmd_data.pair || cmd_data.err || end_of_text);
   end

   // parser state update
   always_comb begin
      acc_in        = acc_ff;
      inside_in     = inside_ff;
      have_start_in = have_start_ff;
      start_raw_in  = start_raw_ff;
      stopped_in    = stopped_ff;
      if (live) begin
         if (is_digit) begin
            acc_in    = acc_sat;
            inside_in = 1'b1;
         end
         if (completed) begin
            acc_in    = '0;
            inside_in = 1'b0;
            if (out_of_range) begin
               stopped_in    = 1'b1;
               have_start_in = 1'b0;
            end else if (!have_start_ff) begin
               start_raw_in  = value[elpr_pkg::RAW_W-1:0];
               have_start_in = 1'b1;
            end else begin
               have_start_in = 1'b0;
            end
         end
         if (end_of_text && !(completed && out_of_range)) begin
            acc_in        = '0;
            inside_in     = 1'b0;
            have_start_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff        <= '0;
         inside_ff     <= 1'b0;
         have_start_ff <= 1'b0;
         stopped_ff    <= 1'b0;
      end else begin
         acc_ff        <= acc_in;
         inside_ff     <= inside_in;
         have_start_ff <= have_start_in;
         stopped_ff    <= stopped_in;
      end
   end

   always_ff @(posedge clock) begin
      start_raw_ff <= start_raw_in;
   end

   // once stopped, the parser stays cleared
   a_stopped_clear: assert property (@(posedge clock) disable iff (reset)
      stopped_ff |-> (!have_start_ff && !inside_ff))
      else $error("front: stopped with a number or start pending");

   // stopping only follows an error request
   a_stop_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(stopped_ff) |-> $past(cmd_push && cmd_data.err))
      else $error("front: stopped without an error request");

endmodule

`default_nettype wire

// File: rtl/elpr_back.sv
// Renumbering back: clears and owns the id map, resolves the dense ids of
// each pair and expands commands into result items. Depends on elpr_pkg.
`default_nettype none

module elpr_back #(
   parameter int MAX_NODES = elpr_pkg::MAX_NODES_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  elpr_pkg::elpr_cmd_type cmd_data,
   input  logic                   cmd_empty,
   output logic                   cmd_pop,
   input  logic                   directed,
   output logic                   rsp_push,
   output elpr_pkg::elpr_rsp_type rsp_data,
   input  logic                   rsp_full,
   output logic                   clear_done
);

   localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
   localparam int DW = elpr_pkg::DENSE_W;
   localparam int RW = elpr_pkg::RAW_W;

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_START = 3'd2;
   localparam logic [2:0] S_END   = 3'd3;
   localparam logic [2:0] S_EMIT  = 3'd4;

   typedef struct packed {
      logic err;
      logic fwd;
      logic rev;
      logic done;
   } pend_type;

   logic [2:0]             state_ff, state_in;
   logic [AW-1:0]          clr_addr_ff, clr_addr_in;
   elpr_pkg::elpr_cmd_type cur_ff, cur_in;
   logic [DW-1:0]          dense_s_ff, dense_s_in;
   logic [DW-1:0]          dense_e_ff, dense_e_in;
   pend_type               pend_ff, pend_in;
   logic [RW-1:0]          next_dense_ff, next_dense_in;
   logic [RW-1:0]          first_raw_ff, first_raw_in;

   logic [DW-1:0]          map_mem [MAX_NODES];
   logic [DW-1:0]          rd_data_ff;
   logic [AW-1:0]          rd_addr;
   logic                   wr_en;
   logic [AW-1:0]          wr_addr;
   logic [DW-1:0]          wr_data;

   logic [RW-1:0]          rs_raw;
   logic [DW-1:0]          rs_entry;
   logic                   rs_new;
   logic [DW-1:0]          rs_dense;

   pend_type               pend_left;
   logic                   em_last;
   logic                   take_ok;

   assign clear_done = (state_ff != S_CLEAR);

   // id map: one write port, one registered read port
   assign rd_addr = (state_ff == S_START) ? AW'(cur_ff.end_raw) : AW'(cmd_data.start_raw);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         map_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= map_mem[rd_addr];
   end

   // lookup-or-assign; the end id sees the start's fresh entry by forwarding
   always_comb begin
      rs_raw   = (state_ff == S_END) ? cur_ff.end_raw : cur_ff.start_raw;
      rs_entry = ((state_ff == S_END) && (cur_ff.end_raw == cur_ff.start_raw))
                 ? dense_s_ff : rd_data_ff;
      rs_new   = (rs_entry == '0) && (rs_raw != first_raw_ff);
      rs_dense = rs_new ? next_dense_ff[DW-1:0] : rs_entry;
   end

   // pick the next result of the current request
   always_comb begin
      rsp_data  = '0;
      pend_left = pend_ff;
      if (pend_ff.err) begin
         rsp_data.kind = elpr_pkg::KIND_ERROR;
         pend_left.err = 1'b0;
      end else if (pend_ff.fwd) begin
         rsp_data.kind        = elpr_pkg::KIND_EDGE;
         rsp_data.source_node = dense_s_ff;
         rsp_data.target_node = dense_e_ff;
         pend_left.fwd        = 1'b0;
      end else if (pend_ff.rev) begin
         rsp_data.kind        = elpr_pkg::KIND_EDGE;
         rsp_data.source_node = dense_e_ff;
         rsp_data.target_node = dense_s_ff;
         pend_left.rev        = 1'b0;
      end else begin
         rsp_data.kind  = elpr_pkg::KIND_DONE;
         pend_left.done = 1'b0;
      end
      em_last               = (pend_left == '0);
      rsp_data.final_of_run = em_last;
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      clr_addr_in   = clr_addr_ff;
      cur_in        = cur_ff;
      dense_s_in    = dense_s_ff;
      dense_e_in    = dense_e_ff;
      pend_in       = pend_ff;
      next_dense_in = next_dense_ff;
      first_raw_in  = first_raw_ff;
      wr_en         = 1'b0;
      wr_addr       = clr_addr_ff;
      wr_data       = '0;
      rsp_push      = 1'b0;
      cmd_pop       = 1'b0;
      take_ok       = 1'b0;

      unique case (state_ff)
         S_CLEAR: begin
            wr_en = 1'b1;
            if (clr_addr_ff == AW'(MAX_NODES - 1)) begin
               state_in = S_IDLE;
            end else begin
               clr_addr_in = clr_addr_ff + 1'b1;
            end
         end
         S_IDLE: begin
            take_ok = 1'b1;
         end
         S_START: begin
            wr_en      = rs_new;
            wr_addr    = AW'(rs_raw);
            wr_data    = rs_dense;
            dense_s_in = rs_dense;
            if (rs_new) begin
               next_dense_in = next_dense_ff + 1'b1;
               if (next_dense_ff == '0) begin
                  first_raw_in = rs_raw;
               end
            end
            state_in = S_END;
         end
         S_END: begin
            wr_en      = rs_new;
            wr_addr    = AW'(rs_raw);
            wr_data    = rs_dense;
            dense_e_in = rs_dense;
            if (rs_new) begin
               next_dense_in = next_dense_ff + 1'b1;
            end
            pend_in  = '{err: 1'b0, fwd: 1'b1, rev: !directed, done: cur_ff.done};
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (!rsp_full) begin
               rsp_push = 1'b1;
               pend_in  = pend_left;
               if (em_last) begin
                  state_in = S_IDLE;
                  take_ok  = 1'b1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // take the next request, overlapping the last result of this one
      if (take_ok && !cmd_empty) begin
         cmd_pop = 1'b1;
         cur_in  = cmd_data;
         if (cmd_data.pair) begin
            state_in = S_START;
         end else begin
            pend_in  = '{err: cmd_data.err, fwd: 1'b0, rev: 1'b0, done: cmd_data.done};
            state_in = S_EMIT;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_addr_ff   <= '0;
         pend_ff       <= '0;
         next_dense_ff <= '0;
         first_raw_ff  <= '1;
      end else begin
         state_ff      <= state_in;
         clr_addr_ff   <= clr_addr_in;
         pend_ff       <= pend_in;
         next_dense_ff <= next_dense_in;
         first_raw_ff  <= first_raw_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff     <= cur_in;
      dense_s_ff <= dense_s_in;
      dense_e_ff <= dense_e_in;
   end

   // nothing leaves before the map is cleared
   a_no_rsp_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> (!rsp_push && !cmd_pop))
      else $error("back: activity during map clear");

   // ids are handed out only while resolving a pair
   a_dense_only_resolve: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_START && state_ff != S_END) |=> $stable(next_dense_ff))
      else $error("back: dense id counter moved outside resolve");

   // emitting always has something left to send
   a_emit_pending: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT) |-> (pend_ff != '0))
      else $error("back: emit state with nothing pending");

   // an error result stands alone
   a_err_alone: assert property (@(posedge clock) disable iff (reset)
      pend_ff.err |-> (!pend_ff.fwd && !pend_ff.rev && !pend_ff.done))
      else $error("back: error mixed with other results");

endmodule

`default_nettype wire

// File: rtl/edge_list_parser_renumber.sv
// Top level of the edge list parser with dense node renumbering.
// Depends on elpr_pkg, elpr_fifo, elpr_front and elpr_back.
//
//   channel | ports                                   | handshake
//   --------+-----------------------------------------+-------------------------
//   request | req_text_byte, req_end_of_text          | req_push, req_full
//   result  | rsp_kind, rsp_source_node,              | rsp_empty, rsp_pop
//           | rsp_target_node, rsp_final_of_run       |
//   config  | csr_index, csr_data                     | csr_valid, csr_ready
//
// The front takes one byte per cycle while req_full is low; a request is queued
// only when a pair, an error or the end of text completes. The back resolves
// a pair in S_START and S_END (one map read each for start and end id) and
// sends one result per cycle while the result queue has room.
// After reset the map is cleared; req_full stays high until the clear is done.
// Config writes are always taken (csr_ready is tied high).
`default_nettype none

module edge_list_parser_renumber #(
   parameter int MAX_NODES = elpr_pkg::MAX_NODES_DEFAULT,
   parameter int CMD_DEPTH = elpr_pkg::CMD_DEPTH_DEFAULT,
   parameter int RSP_DEPTH = elpr_pkg::RSP_DEPTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_push,
   output logic                                req_full,
   input  logic [elpr_pkg::BYTE_W-1:0]         req_text_byte,
   input  logic                                req_end_of_text,
   output logic                                rsp_empty,
   input  logic                                rsp_pop,
   output logic [elpr_pkg::KIND_W-1:0]         rsp_kind,
   output logic [elpr_pkg::DENSE_W-1:0]        rsp_source_node,
   output logic [elpr_pkg::DENSE_W-1:0]        rsp_target_node,
   output logic                                rsp_final_of_run,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [elpr_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [elpr_pkg::CSR_DATA_W-1:0]     csr_data
);

   logic [elpr_pkg::CSR_DATA_W-1:0] node_count_ff;
   logic                            directed_ff;

   logic                   req_accept;
   logic                   front_push;
   elpr_pkg::elpr_cmd_type front_cmd;
   logic                   cmd_full;
   logic                   cmd_empty;
   logic                   cmd_pop;
   elpr_pkg::elpr_cmd_type cmd_head;
   logic                   back_push;
   elpr_pkg::elpr_rsp_type back_rsp;
   logic                   rsp_full;
   elpr_pkg::elpr_rsp_type rsp_head;
   logic                   clear_done;

   // configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= elpr_pkg::NODE_COUNT_RESET;
         directed_ff   <= 1'b1;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            elpr_pkg::CSR_NODE_COUNT: node_count_ff <= csr_data;
            elpr_pkg::CSR_DIRECTED:   directed_ff   <= csr_data[0];
            default: ;
         endcase
      end
   end

   // request side
   assign req_full   = cmd_full || !clear_done;
   assign req_accept = req_push && !req_full;

   elpr_front #(
      .MAX_NODES (MAX_NODES)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (req_accept),
      .text_byte   (req_text_byte),
      .end_of_text (req_end_of_text),
      .node_count  (node_count_ff),
      .cmd_push    (front_push),
      .cmd_data    (front_cmd)
   );

   elpr_fifo #(
      .item_type (elpr_pkg::elpr_cmd_type),
      .DEPTH     (CMD_DEPTH)
   ) u_cmd_q (
      .clock     (clock),
      .reset     (reset),
      .push      (front_push),
      .push_data (front_cmd),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .pop_data  (cmd_head),
      .empty     (cmd_empty)
   );

   elpr_back #(
      .MAX_NODES (MAX_NODES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_data   (cmd_head),
      .cmd_empty  (cmd_empty),
      .cmd_pop    (cmd_pop),
      .directed   (directed_ff),
      .rsp_push   (back_push),
      .rsp_data   (back_rsp),
      .rsp_full   (rsp_full),
      .clear_done (clear_done)
   );

   // result side
   elpr_fifo #(
      .item_type (elpr_pkg::elpr_rsp_type),
      .DEPTH     (RSP_DEPTH)
   ) u_rsp_q (
      .clock     (clock),
      .reset     (reset),
      .push      (back_push),
      .push_data (back_rsp),
      .full      (rsp_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_head),
      .empty     (rsp_empty)
   );

   assign rsp_kind         = rsp_head.kind;
   assign rsp_source_node  = rsp_head.source_node;
   assign rsp_target_node  = rsp_head.target_node;
   assign rsp_final_of_run = rsp_head.final_of_run;

endmodule

`default_nettype wire

// File: sim/tb_edge_list_parser_renumber.sv
// Self-checking testbench for edge_list_parser_renumber: text bytes in, edges out.
// Depends on elpr_pkg and the block's RTL. An in-bench parser and renumbering map
// predict the results of unchecked rows; directed rows come first, then random texts.
module tb_edge_list_parser_renumber;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned IDLE_LIMIT    = 200000;
   localparam int unsigned SETTLE_CYCLES = 32;
   localparam int unsigned PHASES        = 5;
   localparam int unsigned PHASE_BYTES   = 22;
   localparam int unsigned RANDOM_NODES_PHASE = 3;

   localparam logic [elpr_pkg::BYTE_W-1:0] SPACE   = 8'h20;
   localparam logic [elpr_pkg::BYTE_W-1:0] NEWLINE = 8'h0A;
   localparam logic [elpr_pkg::BYTE_W-1:0] COMMA   = 8'h2C;

   // per phase register settings and idling; the random-nodes phase draws its count
   localparam int unsigned PHASE_NODES     [PHASES] = '{1, 65536, 131071, 0, 65536};
   localparam bit          PHASE_DIRECTED  [PHASES] = '{1'b0, 1'b0, 1'b1, 1'b0, 1'b1};
   localparam int unsigned PHASE_PUSH_IDLE [PHASES] = '{0, 53, 0, 37, 0};
   localparam int unsigned PHASE_POP_STALL [PHASES] = '{0, 0, 53, 37, 53};

   localparam elpr_pkg::elpr_rsp_type DONE_LAST  =
      '{elpr_pkg::KIND_DONE, 16'd0, 16'd0, 1'b1};
   localparam elpr_pkg::elpr_rsp_type ERROR_LAST =
      '{elpr_pkg::KIND_ERROR, 16'd0, 16'd0, 1'b1};

   // one text byte plus, where it is obvious, the results it must cause
   typedef struct {
      bit [elpr_pkg::BYTE_W-1:0] text;
      bit                        eot;
      bit                        typed;
      int                        n;
      elpr_pkg::elpr_rsp_type    r0;
      elpr_pkg::elpr_rsp_type    r1;
   } text_row_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_push = 1'b0;
   logic                            req_full;
   logic [elpr_pkg::BYTE_W-1:0]     req_text_byte = '0;
   logic                            req_end_of_text = 1'b0;
   logic                            rsp_empty;
   logic                            rsp_pop = 1'b0;
   logic [elpr_pkg::KIND_W-1:0]     rsp_kind;
   logic [elpr_pkg::DENSE_W-1:0]    rsp_source_node;
   logic [elpr_pkg::DENSE_W-1:0]    rsp_target_node;
   logic                            rsp_final_of_run;
   logic                            csr_valid = 1'b0;
   logic                            csr_ready;
   logic [elpr_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [elpr_pkg::CSR_DATA_W-1:0] csr_data = '0;

   edge_list_parser_renumber u_top (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_text_byte    (req_text_byte),
      .req_end_of_text  (req_end_of_text),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_kind         (rsp_kind),
      .rsp_source_node  (rsp_source_node),
      .rsp_target_node  (rsp_target_node),
      .rsp_final_of_run (rsp_final_of_run),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // parser and renumbering state as the block should hold it
   bit [elpr_pkg::CSR_DATA_W-1:0] cfg_node_count = elpr_pkg::NODE_COUNT_RESET;
   bit                            cfg_directed = 1'b1;
   bit [elpr_pkg::ACC_W-1:0]      acc = '0;
   bit                            in_number = 1'b0;
   bit                            have_start = 1'b0;
   bit [elpr_pkg::RAW_W-1:0]      start_raw = '0;
   bit [elpr_pkg::RAW_W-1:0]      next_dense = '0;
   bit [elpr_pkg::RAW_W-1:0]      dense0_raw = '1;
   bit [elpr_pkg::DENSE_W-1:0]    dense_of_raw [elpr_pkg::MAX_NODES_DEFAULT];
   bit                            halted = 1'b0;

   elpr_pkg::elpr_rsp_type step_results[$];
   elpr_pkg::elpr_rsp_type pending_results[$];
   text_row_type           text_rows[$];

   int unsigned push_idle_pct = 0;
   int unsigned pop_stall_pct = 0;
   int unsigned mismatches = 0;
   int unsigned bytes_sent = 0;
   int unsigned results_seen = 0;
   int unsigned edges_seen = 0;
   int unsigned quiet_cycles = 0;

   // dense id lookup; a zero entry is unmapped unless it belongs to the dense-zero raw id
   function automatic bit [elpr_pkg::DENSE_W-1:0] renumber(
         input bit [elpr_pkg::RAW_W-1:0] raw, input bit may_claim);
      bit [elpr_pkg::DENSE_W-1:0] dense;
      dense = dense_of_raw[raw];
      if (dense == '0 && raw != dense0_raw) begin
         dense = next_dense[elpr_pkg::DENSE_W-1:0];
         dense_of_raw[raw] = dense;
         if (may_claim && next_dense == '0)
            dense0_raw = raw;
         next_dense = next_dense + 1'b1;
      end
      return dense;
   endfunction

   // results caused by one text byte, left in step_results
   function automatic void parse_text_byte(input bit [elpr_pkg::BYTE_W-1:0] b, input bit eot);
      bit                         is_digit;
      bit                         number_done;
      int unsigned                grown;
      int unsigned                value;
      int unsigned                limit;
      bit [elpr_pkg::DENSE_W-1:0] src;
      bit [elpr_pkg::DENSE_W-1:0] dst;
      step_results.delete();
      if (halted)
         return;
      is_digit = b >= elpr_pkg::CHAR_ZERO && b <= elpr_pkg::CHAR_NINE;
      number_done = 1'b0;
      if (is_digit) begin
         grown = 32'(acc) * 32'(elpr_pkg::RADIX) + 32'(b - elpr_pkg::CHAR_ZERO);
         acc = (grown > 32'(elpr_pkg::ACC_MAX)) ? elpr_pkg::ACC_MAX
                                                : grown[elpr_pkg::ACC_W-1:0];
         in_number = 1'b1;
         number_done = eot;
      end else if (in_number) begin
         number_done = 1'b1;
      end

      if (number_done) begin
         value = 32'(acc);
         limit = (32'(cfg_node_count) < elpr_pkg::MAX_NODES_DEFAULT)
                 ? 32'(cfg_node_count) : elpr_pkg::MAX_NODES_DEFAULT;
         acc = '0;
         in_number = 1'b0;
         // out of range id: one error, then everything is ignored
         if (value >= limit) begin
            step_results.insert(step_results.size(), ERROR_LAST);
            halted = 1'b1;
            have_start = 1'b0;
            return;
         end
         if (!have_start) begin
            start_raw = value[elpr_pkg::RAW_W-1:0];
            have_start = 1'b1;
         end else begin
            src = renumber(start_raw, 1'b1);
            dst = renumber(value[elpr_pkg::RAW_W-1:0], 1'b0);
            have_start = 1'b0;
            step_results.insert(step_results.size(), '{elpr_pkg::KIND_EDGE, src, dst, 1'b0});
            if (!cfg_directed)
               step_results.insert(step_results.size(),
                                   '{elpr_pkg::KIND_EDGE, dst, src, 1'b0});
         end
      end

      if (eot) begin
         step_results.insert(step_results.size(), '{elpr_pkg::KIND_DONE, 16'd0, 16'd0, 1'b0});
         acc = '0;
         in_number = 1'b0;
         have_start = 1'b0;
      end
      if (step_results.size() != 0)
         step_results[step_results.size()-1].final_of_run = 1'b1;
   endfunction

   function automatic void add_row(input bit [elpr_pkg::BYTE_W-1:0] b, input bit eot);
      text_rows.insert(text_rows.size(), '{b, eot, 1'b0, 0, '0, '0});
   endfunction

   function automatic void add_checked(input bit [elpr_pkg::BYTE_W-1:0] b, input bit eot,
                                       input int n,
                                       input elpr_pkg::elpr_rsp_type r0 = '0,
                                       input elpr_pkg::elpr_rsp_type r1 = '0);
      text_rows.insert(text_rows.size(), '{b, eot, 1'b1, n, r0, r1});
   endfunction

   // decimal digits of a raw id, optionally with leading zeros
   function automatic void add_number(input int unsigned value, input int unsigned zeros);
      bit [elpr_pkg::BYTE_W-1:0] digits[$];
      do begin
         digits.push_front(8'(elpr_pkg::CHAR_ZERO + value % elpr_pkg::RADIX));
         value = value / elpr_pkg::RADIX;
      end while (value != 0);
      repeat (zeros) digits.push_front(elpr_pkg::CHAR_ZERO);
      foreach (digits[i])
         add_row(digits[i], 1'b0);
   endfunction

   function automatic bit [elpr_pkg::BYTE_W-1:0] separator();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 30)
         return SPACE;
      if (r < 45)
         return NEWLINE;
      if (r < 55)
         return COMMA;
      // any non-digit byte
      r = $urandom_range(0, 245);
      return (r < elpr_pkg::CHAR_ZERO) ? r[elpr_pkg::BYTE_W-1:0] : 8'(r + 10);
   endfunction

   function automatic int unsigned node_limit();
      return (32'(cfg_node_count) < elpr_pkg::MAX_NODES_DEFAULT)
             ? 32'(cfg_node_count) : elpr_pkg::MAX_NODES_DEFAULT;
   endfunction

   // mostly a small pool so ids repeat, plus the top id and anything in range
   function automatic int unsigned pick_raw(input int unsigned limit);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 50)
         return $urandom_range(0, (limit - 1 < 7) ? limit - 1 : 7);
      if (r < 65)
         return limit - 1;
      return $urandom_range(0, limit - 1);
   endfunction

   // one random text, ending with end_of_text on a digit or a separator
   function automatic void build_text();
      int unsigned limit;
      int unsigned numbers;
      int unsigned k;
      limit = node_limit();
      if ($urandom_range(0, 99) < 10) begin
         repeat ($urandom_range(1, 4)) add_row(separator(), 1'b0);
      end else begin
         // mostly whole pairs, sometimes a dangling start
         numbers = ($urandom_range(0, 99) < 75) ? 2 * $urandom_range(0, 3)
                                                : $urandom_range(0, 5);
         repeat ($urandom_range(0, 2)) add_row(separator(), 1'b0);
         for (k = 0; k < numbers; k++) begin
            add_number(pick_raw(limit), ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0);
            if (k + 1 < numbers)
               repeat ($urandom_range(1, 2)) add_row(separator(), 1'b0);
         end
         repeat ($urandom_range(0, 2)) add_row(separator(), 1'b0);
      end
      if (text_rows.size() == 0)
         add_row(separator(), 1'b0);
      text_rows[text_rows.size()-1].eot = 1'b1;
   endfunction

   // present one byte, wait for the request to be taken, then predict
   task automatic send_byte(input text_row_type row);
      while ($urandom_range(0, 99) < push_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push        <= 1'b1;
      req_text_byte   <= row.text;
      req_end_of_text <= row.eot;
      @(posedge clock);
      while (req_full)
         @(posedge clock);
      bytes_sent++;
      parse_text_byte(row.text, row.eot);
      if (row.typed) begin
         if (row.n > 0)
            pending_results.insert(pending_results.size(), row.r0);
         if (row.n > 1)
            pending_results.insert(pending_results.size(), row.r1);
      end else begin
         foreach (step_results[i])
            pending_results.insert(pending_results.size(), step_results[i]);
      end
   endtask

   task automatic send_rows();
      foreach (text_rows[i])
         send_byte(text_rows[i]);
      text_rows.delete();
   endtask

   // stop sending, let every result drain, then give the back end time to settle
   task automatic wait_drained();
      req_push <= 1'b0;
      while (pending_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_settings(input bit [elpr_pkg::CSR_DATA_W-1:0] nodes, input bit dir);
      csr_valid <= 1'b1;
      csr_index <= elpr_pkg::CSR_NODE_COUNT;
      csr_data  <= nodes;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      cfg_node_count = nodes;
      csr_index <= elpr_pkg::CSR_DIRECTED;
      csr_data  <= {{(elpr_pkg::CSR_DATA_W-1){1'b0}}, dir};
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      cfg_directed = dir;
      csr_valid <= 1'b0;
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatches++;
      $display("%0t ns: %s got %0d, expected %0d", $time, what, got, want);
   endtask

   // receiver stalls
   always @(posedge clock)
      rsp_pop <= ($urandom_range(0, 99) >= pop_stall_pct);

   // compare each accepted result with the oldest prediction
   always @(posedge clock) begin : check_results
      elpr_pkg::elpr_rsp_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         results_seen++;
         if (rsp_kind == elpr_pkg::KIND_EDGE)
            edges_seen++;
         if (pending_results.size() == 0) begin
            report_mismatch("result with nothing pending, kind", 32'(rsp_kind), 32'hx);
         end else begin
            want = pending_results.pop_front();
            if (rsp_kind !== want.kind)
               report_mismatch("kind", 32'(rsp_kind), 32'(want.kind));
            if (rsp_source_node !== want.source_node)
               report_mismatch("source_node", 32'(rsp_source_node), 32'(want.source_node));
            if (rsp_target_node !== want.target_node)
               report_mismatch("target_node", 32'(rsp_target_node), 32'(want.target_node));
            if (rsp_final_of_run !== want.final_of_run)
               report_mismatch("final_of_run", 32'(rsp_final_of_run),
                               32'(want.final_of_run));
         end
      end
   end

   // watchdog: too long without any handshake ends the run
   always @(posedge clock) begin
      if ((req_push && !req_full) || (rsp_pop && !rsp_empty) || (csr_valid && csr_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= IDLE_LIMIT) begin
         $display("watchdog: %0d quiet cycles, %0d results outstanding",
                  quiet_cycles, pending_results.size());
         $display("end of test: mismatches");
         $finish;
      end
   end

   initial begin : stimulus
      int unsigned phase;
      int unsigned phase_start;
      int unsigned drawn;
      bit [elpr_pkg::CSR_DATA_W-1:0] nodes;
      bit saturate;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed rows at reset settings (all ids valid, directed)
      add_checked(SPACE, 1'b1, 1, DONE_LAST);                       // empty text
      add_number(0, 0);
      add_checked(8'h2F, 1'b0, 0);                                  // byte just below '0'
      add_number(65535, 0);
      // byte just above '9'
      add_checked(8'h3A, 1'b0, 1, '{elpr_pkg::KIND_EDGE, 16'd0, 16'd1, 1'b1});
      add_checked(8'hFF, 1'b0, 0);
      add_number(7, 2);
      add_checked(8'h00, 1'b0, 0);
      // end on a digit; raw id zero keeps dense id zero
      add_checked(elpr_pkg::CHAR_ZERO, 1'b1, 2,
                  '{elpr_pkg::KIND_EDGE, 16'd2, 16'd0, 1'b0}, DONE_LAST);
      add_number(1, 0);
      add_checked(elpr_pkg::CHAR_ZERO + 8'd2, 1'b1, 1, DONE_LAST);   // lone start dropped
      add_number(9, 0);
      add_row(SPACE, 1'b0);
      add_number(9, 0);
      add_row(NEWLINE, 1'b0);
      add_number(4, 0);
      add_checked(NEWLINE, 1'b1, 1, DONE_LAST);
      send_rows();

      // random texts under each setting and idling pattern
      for (phase = 0; phase < PHASES; phase++) begin
         wait_drained();
         drawn = (phase == RANDOM_NODES_PHASE) ? $urandom_range(2, 1000) : PHASE_NODES[phase];
         nodes = drawn[elpr_pkg::CSR_DATA_W-1:0];
         write_settings(nodes, PHASE_DIRECTED[phase]);
         push_idle_pct = PHASE_PUSH_IDLE[phase];
         pop_stall_pct = PHASE_POP_STALL[phase];
         phase_start = bytes_sent;
         while (bytes_sent - phase_start < PHASE_BYTES) begin
            build_text();
            send_rows();
         end
      end

      // closing error: saturated number or the first id past the limit, then ignored bytes
      saturate = ($urandom_range(0, 1) != 0);
      add_number(saturate ? 9999999 : node_limit(), 0);
      add_checked(COMMA, 1'b0, 1, ERROR_LAST);
      add_checked(elpr_pkg::CHAR_ZERO + 8'd3, 1'b0, 0);
      add_checked(NEWLINE, 1'b1, 0);
      send_rows();
      wait_drained();

      $display("%0d text bytes over %0d register settings; %0d results checked, %0d edges",
               bytes_sent, PHASES + 1, results_seen, edges_seen);
      $display("closing error came from %s", saturate ? "a saturated number" : "the limit id");
      if (mismatches == 0 && pending_results.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

// File: edge_list_parser_renumber.f
rtl/elpr_pkg.sv
rtl/elpr_fifo.sv
rtl/elpr_front.sv
rtl/elpr_back.sv
rtl/edge_list_parser_renumber.sv
sim/tb_edge_list_parser_renumber.sv
